@@ hdl/associated_legendre_evaluator_macros.svh @@
// Assertion helpers for the Legendre evaluator.
// Every use needs clk and arst_n in scope.
`ifndef ASSOCIATED_LEGENDRE_EVALUATOR_MACROS_SVH
`define ASSOCIATED_LEGENDRE_EVALUATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ hdl/ale_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ale_pkg
// Shared constants and types for the associated Legendre evaluator.
// ----------------------------------------------------------------------------
package ale_pkg;

	localparam int L_MAX_DEF     = 8;
	localparam int FRAC_BITS_DEF = 30;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_SAT     = 2'd2;

	// Request to the shared multiply unit
	typedef struct packed {
		logic start;
		logic frac;   // shift the product right by the fraction width
	} ale_mul_req_t;

	// Response from the shared multiply unit
	typedef struct packed {
		logic done;
		logic sat;
	} ale_mul_rsp_t;

endpackage
`default_nettype wire

@@ hdl/associated_legendre_evaluator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sequence per beat: when order is above zero, a multiply, a square root and one
// multiply per order step; one more multiply when degree exceeds order; and for
// each further degree step two multiplies and a divide.
// Throughput: one beat at a time; the next beat is taken the cycle after the result
// has gone to the output register.
// Reset: arst_n clears the sequencer and the output valid; no memory clearing.
// ----------------------------------------------------------------------------
// associated_legendre_evaluator
// Evaluates P_l^m(x) in fixed point by the upward recurrence on a shared
// multiply unit, with iterative square root and small divide.
// ----------------------------------------------------------------------------
module associated_legendre_evaluator #(
	parameter int L_MAX     = ale_pkg::L_MAX_DEF,
	parameter int FRAC_BITS = ale_pkg::FRAC_BITS_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire  [3:0]               degree,
	input  wire  [3:0]               order,
	input  wire  logic signed [31:0] arg,
	output logic                     out_valid,
	input  wire                      out_stall,
	output logic signed [63:0]       value,
	output logic [1:0]               status
);
	import ale_pkg::*;
	`include "associated_legendre_evaluator_macros.svh"

	typedef enum logic [13:0] {
		IDLE   = 14'b00000000000001,
		SQ_GO  = 14'b00000000000010,
		SQ_W   = 14'b00000000000100,
		RT_W   = 14'b00000000001000,
		PMM_GO = 14'b00000000010000,
		PMM_W  = 14'b00000000100000,
		P1_GO  = 14'b00000001000000,
		P1_W   = 14'b00000010000000,
		RA_GO  = 14'b00000100000000,
		RA_W   = 14'b00001000000000,
		RB_GO  = 14'b00010000000000,
		RB_W   = 14'b00100000000000,
		DV_W   = 14'b01000000000000,
		FIN    = 14'b10000000000000
	} ale_state_t;

	localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

	ale_state_t         state_q;
	logic [3:0]         l_q, m_q, i_q, ll_q;
	logic signed [63:0] x_q, pmm_q, pmmp1_q, a_q, res_q, x_in;
	logic               sat_q, neg_q;
	logic [1:0]         st_q;
	logic [63:0]        s_q;

	ale_mul_req_t       mreq;
	ale_mul_rsp_t       mrsp;
	logic signed [63:0] mop_a, mop_b, mres, num;
	logic [127:0]       mfull;
	logic               sq_done, dv_done, accept, bad, sub_sat;
	logic [63:0]        root, quot, num_mag;
	logic [4:0]         coef;
	logic [64:0]        diff;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != IDLE);
	assign x_in     = 64'(arg);
	assign bad      = (order > degree) || (32'(degree) > 32'(L_MAX)) ||
	                  (x_in > ONE) || (x_in < -ONE);

	// Odd coefficient for the current multiply
	always_comb begin
		priority case (1'b1)
			state_q == PMM_GO: coef = 5'({i_q, 1'b0} - 5'd1);
			state_q == P1_GO:  coef = 5'({m_q, 1'b0} + 5'd1);
			default:           coef = 5'({ll_q, 1'b0} - 5'd1);
		endcase
	end

	// Operand selection for the shared multiplier
	always_comb begin
		mreq.start = 1'b0;
		mreq.frac  = 1'b1;
		mop_a      = pmm_q;
		mop_b      = x_q * $signed({1'b0, coef});
		unique case (state_q)
			SQ_GO: begin
				mreq.start = 1'b1;
				mreq.frac  = 1'b0;
				mop_a      = ONE - x_q;
				mop_b      = ONE + x_q;
			end
			PMM_GO: begin
				mreq.start = 1'b1;
				mop_b      = -$signed(64'(s_q * 64'(coef)));
			end
			P1_GO: mreq.start = 1'b1;
			RA_GO: begin
				mreq.start = 1'b1;
				mop_a      = pmmp1_q;
			end
			RB_GO: begin
				mreq.start = 1'b1;
				mreq.frac  = 1'b0;
				mop_b      = 64'(5'(ll_q) + 5'(m_q) - 5'd1);
			end
			default: ;
		endcase
	end

	// Saturating difference a - b
	assign diff    = {a_q[63], a_q} - {mres[63], mres};
	assign sub_sat = diff[64] != diff[63];
	assign num     = sub_sat ? (diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
	                         : $signed(diff[63:0]);
	assign num_mag = num[63] ? 64'(-num) : 64'(num);

	ale_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .req(mreq), .op_a(mop_a), .op_b(mop_b),
		.rsp(mrsp), .res(mres), .full(mfull)
	);

	ale_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(state_q == SQ_W && mrsp.done),
		.rad(mfull), .done(sq_done), .root(root)
	);

	ale_div u_div (
		.clk(clk), .arst_n(arst_n), .start(state_q == RB_W && mrsp.done),
		.dividend(num_mag), .divisor(ll_q - m_q), .done(dv_done), .quot(quot)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			out_valid <= 1'b0;
		end else begin
			if (state_q == FIN && (!out_valid || !out_stall))
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				IDLE: if (accept) begin
					if (bad)
						state_q <= FIN;
					else if (order == 4'd0)
						state_q <= (degree == 4'd0) ? FIN : P1_GO;
					else
						state_q <= SQ_GO;
				end
				SQ_GO:  state_q <= SQ_W;
				SQ_W:   if (mrsp.done) state_q <= RT_W;
				RT_W:   if (sq_done) state_q <= PMM_GO;
				PMM_GO: state_q <= PMM_W;
				PMM_W:  if (mrsp.done) begin
					if (i_q != m_q)
						state_q <= PMM_GO;
					else
						state_q <= (l_q == m_q) ? FIN : P1_GO;
				end
				P1_GO:  state_q <= P1_W;
				P1_W:   if (mrsp.done)
					state_q <= (l_q == m_q + 4'd1) ? FIN : RA_GO;
				RA_GO:  state_q <= RA_W;
				RA_W:   if (mrsp.done) state_q <= RB_GO;
				RB_GO:  state_q <= RB_W;
				RB_W:   if (mrsp.done) state_q <= DV_W;
				DV_W:   if (dv_done) state_q <= (ll_q == l_q) ? FIN : RA_GO;
				FIN:    if (!out_valid || !out_stall)
					state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			IDLE: begin
				l_q   <= degree;
				m_q   <= order;
				x_q   <= x_in;
				pmm_q <= ONE;
				res_q <= bad ? '0 : ONE;
				sat_q <= 1'b0;
				i_q   <= 4'd1;
				st_q  <= bad ? ST_INVALID : ST_OK;
			end
			RT_W: if (sq_done) s_q <= root;
			PMM_W: if (mrsp.done) begin
				pmm_q <= mres;
				res_q <= mres;
				sat_q <= sat_q | mrsp.sat;
				i_q   <= i_q + 4'd1;
			end
			P1_W: if (mrsp.done) begin
				pmmp1_q <= mres;
				res_q   <= mres;
				sat_q   <= sat_q | mrsp.sat;
				ll_q    <= m_q + 4'd2;
			end
			RA_W: if (mrsp.done) begin
				a_q   <= mres;
				sat_q <= sat_q | mrsp.sat;
			end
			RB_W: if (mrsp.done) begin
				neg_q <= num[63];
				sat_q <= sat_q | mrsp.sat | sub_sat;
			end
			DV_W: if (dv_done) begin
				pmm_q   <= pmmp1_q;
				pmmp1_q <= neg_q ? -$signed(quot) : $signed(quot);
				res_q   <= neg_q ? -$signed(quot) : $signed(quot);
				ll_q    <= ll_q + 4'd1;
			end
			FIN: if (!out_valid || !out_stall) begin
				value  <= res_q;
				status <= (st_q == ST_INVALID) ? ST_INVALID :
				          (sat_q ? ST_SAT : ST_OK);
			end
			default: ;
		endcase
	end

	`ALE_ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "accepted beat not held busy")
	`ALE_ASSERT_SAME(a_invalid_zero, out_valid && status == ST_INVALID, value == 64'sd0,
		"invalid result carries a value")
	`ALE_ASSERT_SAME(a_mul_done_waited, mrsp.done,
		state_q == SQ_W || state_q == PMM_W || state_q == P1_W || state_q == RA_W ||
		state_q == RB_W, "multiply finished outside a wait state")
	`ALE_ASSERT_SAME(a_status_range, out_valid,
		status == ST_OK || status == ST_INVALID || status == ST_SAT,
		"status code out of range")

endmodule
`default_nettype wire

@@ hdl/ale_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ale_mul
// Shared signed 64x64 multiply with optional fraction shift and clamping.
// One 32x32 partial product a cycle.
// ----------------------------------------------------------------------------
module ale_mul #(
	parameter int FRAC_BITS = ale_pkg::FRAC_BITS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire ale_pkg::ale_mul_req_t req,
	input  wire logic signed [63:0]   op_a,
	input  wire logic signed [63:0]   op_b,
	output ale_pkg::ale_mul_rsp_t     rsp,
	output logic signed [63:0]        res,
	output logic [127:0]              full
);
	import ale_pkg::*;

	logic [63:0]  ma_q, mb_q;
	logic         neg_q, frac_q, busy_q, done_q, sat_q;
	logic [2:0]   step_q;
	logic [63:0]  pp_q;
	logic [1:0]   off_q;
	logic [127:0] acc_q, addend, shifted;
	logic [31:0]  ha, hb;
	logic [63:0]  lo;
	logic signed [63:0] fin;
	logic         fin_sat;

	// Operand halves for the current partial product
	assign ha = step_q[0] ? ma_q[63:32] : ma_q[31:0];
	assign hb = step_q[1] ? mb_q[63:32] : mb_q[31:0];

	always_comb begin
		unique case (off_q)
			2'd0:    addend = {64'd0, pp_q};
			2'd1:    addend = {32'd0, pp_q, 32'd0};
			default: addend = {pp_q, 64'd0};
		endcase
	end

	// Final shift, clamp and sign
	assign shifted = frac_q ? (acc_q >> FRAC_BITS) : acc_q;
	assign lo      = shifted[63:0];
	always_comb begin
		fin_sat = 1'b0;
		if (shifted[127:64] != 64'd0) begin
			fin_sat = 1'b1;
			fin = neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else if (neg_q && lo != 64'd0) begin
			if (lo > {1'b1, 63'd0}) begin
				fin_sat = 1'b1;
				fin = {1'b1, 63'd0};
			end else begin
				fin = -$signed(lo);
			end
		end else if (lo[63]) begin
			fin_sat = 1'b1;
			fin = {1'b0, {63{1'b1}}};
		end else begin
			fin = $signed(lo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q   <= op_a[63] ? 64'(-op_a) : 64'(op_a);
			mb_q   <= op_b[63] ? 64'(-op_b) : 64'(op_b);
			neg_q  <= op_a[63] ^ op_b[63];
			frac_q <= req.frac;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (step_q < 3'd4) begin
				pp_q  <= ha * hb;
				off_q <= 2'(step_q[0]) + 2'(step_q[1]);
			end
			if (step_q >= 3'd1 && step_q <= 3'd4)
				acc_q <= acc_q + addend;
			if (step_q == 3'd5) begin
				res   <= fin;
				sat_q <= fin_sat;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign full     = acc_q;

endmodule
`default_nettype wire

@@ hdl/ale_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ale_sqrt
// Digit-by-digit integer square root of a 128-bit value, one bit a cycle.
// ----------------------------------------------------------------------------
module ale_sqrt (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          start,
	input  wire  [127:0] rad,
	output logic         done,
	output logic [63:0]  root
);
	logic [127:0] rad_q;
	logic [66:0]  rem_q, rem_n, trial;
	logic [5:0]   cnt_q;
	logic         busy_q;

	assign rem_n = {rem_q[64:0], rad_q[127:126]};
	assign trial = {1'b0, root, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// One result bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= rad;
			rem_q <= '0;
			root  <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[125:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q <= rem_n - trial;
				root  <= {root[62:0], 1'b1};
			end else begin
				rem_q <= rem_n;
				root  <= {root[62:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/ale_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ale_div
// Restoring divide of a 64-bit magnitude by a 4-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module ale_div (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [63:0] dividend,
	input  wire  [3:0]  divisor,
	output logic        done,
	output logic [63:0] quot
);
	logic [63:0] dvd_q;
	logic [3:0]  dvs_q, rem_q;
	logic [4:0]  rem_n;
	logic [5:0]  cnt_q;
	logic        busy_q;

	assign rem_n = {rem_q, dvd_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Shift-subtract step
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quot  <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			if (rem_n >= {1'b0, dvs_q}) begin
				rem_q <= 4'(rem_n - {1'b0, dvs_q});
				quot  <= {quot[62:0], 1'b1};
			end else begin
				rem_q <= rem_n[3:0];
				quot  <= {quot[62:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Legendre evaluator testbench
// Drives degree/order/argument beats through the valid/stall handshake with
// random gaps and receiver hold-offs, predicts P_l^m(x) in fixed point with a
// local recurrence model and checks every returned value and status in order.
// ----------------------------------------------------------------------------
module tb;
	import ale_pkg::*;

	localparam int LMAX = 8;
	localparam int FB   = 30;
	localparam longint ONE = 64'sd1 << FB;
	localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
	localparam int N_RANDOM = 2000;
	localparam longint CYCLE_LIMIT = 64'd4_000_000;

	typedef struct packed {
		logic signed [63:0] val;
		logic [1:0]         st;
	} legendre_res_t;

	// Predictor and pending-result store
	class legendre_board;
		legendre_res_t pending[$];
		int mismatches;
		int checked;
		bit clamped;

		function automatic logic [63:0] mag(longint v);
			return v < 0 ? -v : v;
		endfunction

		function automatic longint from_mag(logic [63:0] m, bit neg);
			if (neg) begin
				if (m > 64'h8000_0000_0000_0000) begin
					clamped = 1;
					return I64_MIN;
				end
				return -m;
			end
			if (m > 64'h7FFF_FFFF_FFFF_FFFF) begin
				clamped = 1;
				return I64_MAX;
			end
			return m;
		endfunction

		function automatic longint prod_shift(longint a, longint b, int sh);
			logic [127:0] p;
			bit neg;
			neg = (a < 0) != (b < 0);
			p = {64'd0, mag(a)} * {64'd0, mag(b)};
			p = p >> sh;
			if (p[127:64] != 0) begin
				clamped = 1;
				return neg ? I64_MIN : I64_MAX;
			end
			return from_mag(p[63:0], neg && p[63:0] != 0);
		endfunction

		function automatic longint diff_sat(longint a, longint b);
			logic signed [64:0] d;
			d = 65'(a) - 65'(b);
			if (d > 65'(I64_MAX)) begin
				clamped = 1;
				return I64_MAX;
			end
			if (d < 65'(I64_MIN)) begin
				clamped = 1;
				return I64_MIN;
			end
			return d[63:0];
		endfunction

		function automatic logic [63:0] root_floor(logic [127:0] n);
			logic [63:0] r, c;
			r = 0;
			for (int b = 63; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if ({64'd0, c} * {64'd0, c} <= n)
					r = c;
			end
			return r;
		endfunction

		function automatic legendre_res_t evaluate(int l, int m, longint x);
			legendre_res_t r;
			longint pmm, pmm1, res, a, b, num;
			logic [63:0] s;
			clamped = 0;
			if (m > l || l > LMAX || x > ONE || x < -ONE) begin
				r.val = 0;
				r.st = ST_INVALID;
				return r;
			end
			pmm = ONE;
			if (m > 0) begin
				s = root_floor({64'd0, 64'(ONE - x)} * {64'd0, 64'(ONE + x)});
				for (int i = 1; i <= m; i++)
					pmm = prod_shift(pmm, -longint'(2 * i - 1) * longint'(s), FB);
			end
			if (l == m)
				res = pmm;
			else begin
				pmm1 = prod_shift(pmm, x * (2 * m + 1), FB);
				res = pmm1;
				for (int k = m + 2; k <= l; k++) begin
					a = prod_shift(pmm1, x * (2 * k - 1), FB);
					b = prod_shift(pmm, longint'(k + m - 1), 0);
					num = diff_sat(a, b);
					res = num / longint'(k - m);
					pmm = pmm1;
					pmm1 = res;
				end
			end
			r.val = res;
			r.st = clamped ? ST_SAT : ST_OK;
			return r;
		endfunction

		function void note_input(int l, int m, logic signed [31:0] x);
			pending.push_back(evaluate(l, m, longint'(x)));
		endfunction

		function void check_result(logic signed [63:0] v, logic [1:0] st);
			legendre_res_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result value=%0d status=%0d", v, st);
				return;
			end
			e = pending.pop_front();
			if (e.val !== v || e.st !== st) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d expected value=%0d status=%0d, got value=%0d status=%0d",
						checked, e.val, e.st, v, st);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [3:0] degree, order;
	logic signed [31:0] arg;
	logic signed [63:0] value;
	logic [1:0] status;

	legendre_board board;
	longint cycles = 0;
	bit hold_off;
	int n_sent, n_sat, n_inval;

	associated_legendre_evaluator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.degree(degree), .order(order), .arg(arg),
		.out_valid(out_valid), .out_stall(out_stall),
		.value(value), .status(status)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Cycle count and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Send one beat, after a random gap, and wait for acceptance
	task automatic send_beat(int l, int m, logic signed [31:0] x);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		degree <= 4'(l);
		order <= 4'(m);
		arg <= x;
		do @(posedge clk); while (in_stall);
		board.note_input(l, m, x);
		n_sent++;
	endtask

	function automatic logic signed [31:0] rand_arg();
		case ($urandom_range(0, 9))
			0: return 32'(ONE);
			1: return -32'(ONE);
			2: return 0;
			3: return $urandom();
			4: return 32'(ONE) - $urandom_range(0, 100);
			default: return $signed($urandom_range(0, 2 * 32'(ONE))) - 32'(ONE);
		endcase
	endfunction

	// Result side: random stalls, one long hold-off on request
	initial begin
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off)
				out_stall <= 1;
			else if ($urandom_range(0, 2) == 0)
				out_stall <= ($urandom_range(0, 1) == 1);
			else
				out_stall <= 0;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall) begin
			if (status == ST_SAT) n_sat++;
			if (status == ST_INVALID) n_inval++;
			board.check_result(value, status);
		end

	// Long receiver hold-off while the sender keeps offering
	initial begin
		hold_off = 0;
		wait (n_sent == 40);
		hold_off = 1;
		repeat (600) @(posedge clk);
		hold_off = 0;
	end

	initial begin
		logic signed [31:0] x;
		int l, m;
		board = new();
		in_valid = 0;
		degree = 0;
		order = 0;
		arg = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes and each invalid case
		send_beat(0, 0, 0);
		send_beat(8, 0, 32'(ONE));
		send_beat(8, 8, 0);
		send_beat(8, 8, -32'(ONE));
		send_beat(8, 3, -32'(ONE));
		send_beat(1, 1, 32'sd536870912);
		send_beat(2, 3, 0);
		send_beat(15, 0, 0);
		send_beat(9, 2, 0);
		send_beat(15, 15, 32'hFFFF_FFFF);
		send_beat(4, 2, 32'(ONE) + 1);
		send_beat(4, 2, -32'(ONE) - 1);
		send_beat(3, 1, 32'h7FFF_FFFF);
		send_beat(3, 1, 32'h8000_0000);
		send_beat(8, 7, 32'sd123456789);
		send_beat(7, 0, -32'sd987654321);
		send_beat(5, 5, 32'sd1);

		// Random: mostly valid requests, some out of range
		for (int n = 0; n < N_RANDOM; n++) begin
			if ($urandom_range(0, 9) == 0) begin
				l = $urandom_range(0, 15);
				m = $urandom_range(0, 15);
			end else begin
				l = $urandom_range(0, LMAX);
				m = $urandom_range(0, l);
			end
			x = rand_arg();
			send_beat(l, m, x);
		end
		in_valid <= 0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d requests (%0d invalid, %0d saturated results) over %0d cycles",
			n_sent, n_inval, n_sat, cycles);
		if (board.mismatches == 0)
			$display("== PASS ==");
		else begin
			$display("%0d mismatches", board.mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
